[rtl/bru_pkg.sv]
// ----------------------------------------------------------------------------
// bru_pkg: shared types and constants for the belief revision update block
// Fixed-point format, pipeline depth, divider geometry and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bru_pkg;

  // fixed-point format of strength and confidence
  localparam int FRAC_BITS   = 15;
  localparam int FRAC_W      = 16;
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int HALF        = ONE >> 1;
  localparam int SAT_TOP_INT = (ONE < 65535) ? ONE : 65535;
  localparam logic [FRAC_W-1:0] SAT_TOP  = FRAC_W'(SAT_TOP_INT);
  localparam logic [FRAC_W-1:0] HALF_VAL = FRAC_W'(HALF);

  // other field widths
  localparam int IMP_W       = 16;
  localparam int IMP_EXT_W   = IMP_W + 2;
  localparam int COUNT_WIDTH = 32;
  localparam int GAIN_W      = 10;
  localparam int LIMIT_W     = 15;

  // arithmetic widths
  localparam int SUM_W  = FRAC_W + 1;          // c1 + c2
  localparam int PROD_W = 2 * FRAC_W;          // 16x16 products
  localparam int NUM_W  = PROD_W + 2;          // dividend
  localparam int DEN_W  = SUM_W + 1;           // divisor
  localparam int QUO_W  = FRAC_W;              // quotient bits produced

  // pipeline geometry
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;
  localparam int FRONT_STAGES   = 2;
  localparam int DIV_FIRST      = FRONT_STAGES;
  localparam int PIPE_STAGES    = FRONT_STAGES + 1 + DIV_STAGES + 1;
  localparam int OUT_STAGE      = PIPE_STAGES - 1;

  // stream widths
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 96;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OBS_CONF   = 3'd0,
    REG_SHORT_GAIN = 3'd1,
    REG_SHORT_LOSS = 3'd2,
    REG_LONG_GAIN  = 3'd3,
    REG_LONG_FAIL  = 3'd4,
    REG_ATT_LIMIT  = 3'd5
  } cfg_reg_e;

  // register reset values
  localparam logic [FRAC_W-1:0]  OBS_CONF_RST   = 16'd29491;
  localparam logic [GAIN_W-1:0]  SHORT_GAIN_RST = 10'd5;
  localparam logic [GAIN_W-1:0]  SHORT_LOSS_RST = 10'd10;
  localparam logic [GAIN_W-1:0]  LONG_GAIN_RST  = 10'd1;
  localparam logic [GAIN_W-1:0]  LONG_FAIL_RST  = 10'd2;
  localparam logic [LIMIT_W-1:0] ATT_LIMIT_RST  = 15'd1000;

  typedef struct packed {
    logic [FRAC_W-1:0]  obs_conf;
    logic [GAIN_W-1:0]  short_gain;
    logic [GAIN_W-1:0]  short_loss;
    logic [GAIN_W-1:0]  long_gain;
    logic [GAIN_W-1:0]  long_fail;
    logic [LIMIT_W-1:0] att_limit;
  } cfg_t;

  // results that ride alongside the dividers
  typedef struct packed {
    logic                   zero_sum;
    logic [IMP_W-1:0]       short_imp;
    logic [IMP_W-1:0]       long_imp;
    logic [COUNT_WIDTH-1:0] count;
  } side_t;

endpackage

`default_nettype wire

[rtl/bru_ctrl.sv]
// ----------------------------------------------------------------------------
// bru_ctrl: pipeline valid bits and per-stage load enables
// A stage loads when it is empty or when the stage after it loads, so
// bubbles close up; an output stall holds full stages up to the first bubble.
// ----------------------------------------------------------------------------
`default_nettype none

module bru_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic                           out_ready_i,
  output logic [bru_pkg::PIPE_STAGES-1:0]     load_o,
  output logic                                out_valid_o
);
  import bru_pkg::*;

  logic [PIPE_STAGES-1:0] valid_q, valid_d;

  // ready chain from the output back to the input
  always_comb begin
    load_o[PIPE_STAGES-1] = !valid_q[PIPE_STAGES-1] || out_ready_i;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      load_o[k] = !valid_q[k] || load_o[k+1];
    end
  end

  // valid bits move with the data
  always_comb begin
    valid_d = valid_q;
    if (load_o[0]) valid_d[0] = in_valid_i;
    for (int k = 1; k < PIPE_STAGES; k++) begin
      if (load_o[k]) valid_d[k] = valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q[PIPE_STAGES-1];

  // a held output item blocks only when every stage is full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_o[0] |-> (valid_q == {PIPE_STAGES{1'b1}}))
    else $error("input stalled with an empty stage");

  // an item leaving the last stage is replaced or the stage empties
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !valid_q[PIPE_STAGES-2]) |=> !out_valid_o)
    else $error("output item repeated");

  // with no new item the valid count cannot grow
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_i |=> ($countones(valid_q) <= $past($countones(valid_q))))
    else $error("item invented in pipeline");

endmodule

`default_nettype wire

[rtl/bru_front.sv]
// ----------------------------------------------------------------------------
// bru_front: products, sums and importance updates
// Stage A forms the 16x16 products, the confidence sum, the clamped
// importance values and the count; stage B forms dividends and divisors.
// ----------------------------------------------------------------------------
`default_nettype none

module bru_front (
  input  wire logic                               clk_i,
  input  wire logic [1:0]                         load_i,
  input  wire bru_pkg::cfg_t                      cfg_i,
  input  wire logic                               success_i,
  input  wire logic [bru_pkg::FRAC_W-1:0]         prior_strength_i,
  input  wire logic [bru_pkg::FRAC_W-1:0]         prior_confidence_i,
  input  wire logic [bru_pkg::IMP_W-1:0]          short_importance_i,
  input  wire logic [bru_pkg::IMP_W-1:0]          long_importance_i,
  input  wire logic [bru_pkg::COUNT_WIDTH-1:0]    access_total_i,
  output logic [bru_pkg::NUM_W-1:0]               num_s_o,
  output logic [bru_pkg::DEN_W-1:0]               den_s_o,
  output logic [bru_pkg::NUM_W-1:0]               num_c_o,
  output logic [bru_pkg::DEN_W-1:0]               den_c_o,
  output bru_pkg::side_t                          side_o
);
  import bru_pkg::*;

  logic [PROD_W-1:0] p_sc_q, p_sc_d;
  logic [PROD_W-1:0] p_cc_q, p_cc_d;
  logic [PROD_W-1:0] s2c2_q, s2c2_d;
  logic [SUM_W-1:0]  csum_q, csum_d;
  side_t             side_a_q, side_a_d;

  logic signed [IMP_EXT_W-1:0] sti, lti, lim, sti_n, lti_n;

  // stage A: products and confidence sum
  always_comb begin
    p_sc_d = prior_strength_i * prior_confidence_i;
    p_cc_d = prior_confidence_i * cfg_i.obs_conf;
    s2c2_d = success_i ? PROD_W'({cfg_i.obs_conf, {FRAC_BITS{1'b0}}}) : '0;
    csum_d = SUM_W'(prior_confidence_i) + SUM_W'(cfg_i.obs_conf);
  end

  // stage A: importance clamps and saturating count
  always_comb begin
    sti = IMP_EXT_W'(signed'(short_importance_i));
    lti = IMP_EXT_W'(signed'(long_importance_i));
    lim = signed'(IMP_EXT_W'(cfg_i.att_limit));
    if (success_i) begin
      sti_n = sti + signed'(IMP_EXT_W'(cfg_i.short_gain));
      if (sti_n > lim) sti_n = lim;
      lti_n = lti + signed'(IMP_EXT_W'(cfg_i.long_gain));
    end else begin
      sti_n = sti - signed'(IMP_EXT_W'(cfg_i.short_loss));
      if (sti_n < -lim) sti_n = -lim;
      lti_n = lti + signed'(IMP_EXT_W'(cfg_i.long_fail));
    end
    if (lti_n > lim) lti_n = lim;
    side_a_d.zero_sum  = (csum_d == '0);
    side_a_d.short_imp = sti_n[IMP_W-1:0];
    side_a_d.long_imp  = lti_n[IMP_W-1:0];
    side_a_d.count     = (&access_total_i) ? access_total_i : access_total_i + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      p_sc_q   <= p_sc_d;
      p_cc_q   <= p_cc_d;
      s2c2_q   <= s2c2_d;
      csum_q   <= csum_d;
      side_a_q <= side_a_d;
    end
  end

  // stage B: dividends and divisors
  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      num_s_o <= NUM_W'(p_sc_q) + NUM_W'(s2c2_q);
      den_s_o <= DEN_W'(csum_q);
      num_c_o <= NUM_W'({csum_q, {FRAC_BITS{1'b0}}});
      den_c_o <= DEN_W'(ONE) + DEN_W'(p_cc_q >> FRAC_BITS);
      side_o  <= side_a_q;
    end
  end

endmodule

`default_nettype wire

[rtl/bru_div.sv]
// ----------------------------------------------------------------------------
// bru_div: pipelined restoring divider
// First stage checks whether the quotient needs more than QUO_W bits and
// loads the partial remainder; each later stage retires two quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bru_div (
  input  wire logic                          clk_i,
  input  wire logic [bru_pkg::DIV_STAGES:0]  load_i,
  input  wire logic [bru_pkg::NUM_W-1:0]     num_i,
  input  wire logic [bru_pkg::DEN_W-1:0]     den_i,
  output logic [bru_pkg::QUO_W-1:0]          quo_o,
  output logic                               ovf_o
);
  import bru_pkg::*;

  logic [DEN_W-1:0] rem_q [DIV_STAGES+1];
  logic [QUO_W-1:0] lq_q  [DIV_STAGES+1];   // dividend bits out, quotient bits in
  logic [DEN_W-1:0] den_q [DIV_STAGES+1];
  logic             ovf_q [DIV_STAGES+1];

  // overflow check and remainder load
  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      ovf_q[0] <= (num_i[NUM_W-1:QUO_W] >= den_i);
      rem_q[0] <= num_i[NUM_W-1:QUO_W];
      lq_q[0]  <= num_i[QUO_W-1:0];
      den_q[0] <= den_i;
    end
  end

  for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_step
    logic [DEN_W-1:0] rem_w;
    logic [QUO_W-1:0] lq_w;
    logic [DEN_W:0]   trial;

    // two shift-compare-subtract steps
    always_comb begin
      rem_w = rem_q[g-1];
      lq_w  = lq_q[g-1];
      trial = '0;
      for (int i = 0; i < BITS_PER_STAGE; i++) begin
        trial = {rem_w, lq_w[QUO_W-1]};
        lq_w  = {lq_w[QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, den_q[g-1]}) begin
          trial    = trial - {1'b0, den_q[g-1]};
          lq_w[0]  = 1'b1;
        end
        rem_w = trial[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (load_i[g]) begin
        rem_q[g] <= rem_w;
        lq_q[g]  <= lq_w;
        den_q[g] <= den_q[g-1];
        ovf_q[g] <= ovf_q[g-1];
      end
    end
  end

  assign quo_o = lq_q[DIV_STAGES];
  assign ovf_o = ovf_q[DIV_STAGES];

endmodule

`default_nettype wire

[rtl/belief_revision_update.sv]
// ----------------------------------------------------------------------------
// belief_revision_update: revises a belief by one success or failure item
// Items enter on the s_axis stream and leave on the m_axis stream; six
// configuration registers are written through cfg_we_i / cfg_index_i /
// cfg_data_i, which the user must do only while the block is idle; the
// block does not enforce it. Writes to indexes beyond the list are ignored.
//
// From an accepted input item to its result on m_axis the pipeline has
// two front stages (products, then sums), one divider setup stage,
// eight divider stages each retiring two of the sixteen quotient bits, and
// the output register. The strength and confidence dividers run side by
// side. Throughput is one item per cycle unless m_axis is stalled.
//
// Every stage carries a valid bit. When the receiver holds m_axis_tready
// low, the result stays in the output register and earlier items keep
// moving into empty stages; s_axis_tready drops only once every stage is
// full. Reset empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module belief_revision_update (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // config write port
  input  wire logic                             cfg_we_i,
  input  wire logic [bru_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [bru_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // success[0], prior_strength[16:1], prior_confidence[32:17],
  // short_importance[48:33], long_importance[64:49], access_total[96:65]
  input  wire logic [bru_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // output stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // revised_strength[15:0], revised_confidence[31:16],
  // next_short_importance[47:32], next_long_importance[63:48],
  // next_access_total[95:64]
  output logic [bru_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
  import bru_pkg::*;

  cfg_t                   cfg_q;
  logic [PIPE_STAGES-1:0] load;

  logic [NUM_W-1:0] num_s, num_c;
  logic [DEN_W-1:0] den_s, den_c;
  side_t            side_b;
  side_t            side_q [DIV_STAGES+1];
  logic [QUO_W-1:0] quo_s, quo_c;
  logic             ovf_s, ovf_c;
  logic [FRAC_W-1:0] rs_d, rc_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.obs_conf   <= OBS_CONF_RST;
      cfg_q.short_gain <= SHORT_GAIN_RST;
      cfg_q.short_loss <= SHORT_LOSS_RST;
      cfg_q.long_gain  <= LONG_GAIN_RST;
      cfg_q.long_fail  <= LONG_FAIL_RST;
      cfg_q.att_limit  <= ATT_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_OBS_CONF:   cfg_q.obs_conf   <= cfg_data_i[FRAC_W-1:0];
        REG_SHORT_GAIN: cfg_q.short_gain <= cfg_data_i[GAIN_W-1:0];
        REG_SHORT_LOSS: cfg_q.short_loss <= cfg_data_i[GAIN_W-1:0];
        REG_LONG_GAIN:  cfg_q.long_gain  <= cfg_data_i[GAIN_W-1:0];
        REG_LONG_FAIL:  cfg_q.long_fail  <= cfg_data_i[GAIN_W-1:0];
        REG_ATT_LIMIT:  cfg_q.att_limit  <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  bru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .load_o      (load),
    .out_valid_o (m_axis_tvalid)
  );

  assign s_axis_tready = load[0];

  // front stages
  bru_front u_front (
    .clk_i              (clk_i),
    .load_i             (load[1:0]),
    .cfg_i              (cfg_q),
    .success_i          (s_axis_tdata[0]),
    .prior_strength_i   (s_axis_tdata[16:1]),
    .prior_confidence_i (s_axis_tdata[32:17]),
    .short_importance_i (s_axis_tdata[48:33]),
    .long_importance_i  (s_axis_tdata[64:49]),
    .access_total_i     (s_axis_tdata[96:65]),
    .num_s_o            (num_s),
    .den_s_o            (den_s),
    .num_c_o            (num_c),
    .den_c_o            (den_c),
    .side_o             (side_b)
  );

  // strength and confidence dividers
  bru_div u_div_s (
    .clk_i  (clk_i),
    .load_i (load[DIV_FIRST +: DIV_STAGES+1]),
    .num_i  (num_s),
    .den_i  (den_s),
    .quo_o  (quo_s),
    .ovf_o  (ovf_s)
  );

  bru_div u_div_c (
    .clk_i  (clk_i),
    .load_i (load[DIV_FIRST +: DIV_STAGES+1]),
    .num_i  (num_c),
    .den_i  (den_c),
    .quo_o  (quo_c),
    .ovf_o  (ovf_c)
  );

  // delay line for importance and count alongside the dividers
  always_ff @(posedge clk_i) begin
    if (load[DIV_FIRST]) side_q[0] <= side_b;
    for (int j = 1; j <= DIV_STAGES; j++) begin
      if (load[DIV_FIRST+j]) side_q[j] <= side_q[j-1];
    end
  end

  // saturation and zero confidence sum
  always_comb begin
    if (side_q[DIV_STAGES].zero_sum) begin
      rs_d = HALF_VAL;
      rc_d = '0;
    end else begin
      rs_d = (ovf_s || quo_s > SAT_TOP) ? SAT_TOP : quo_s;
      rc_d = (ovf_c || quo_c > SAT_TOP) ? SAT_TOP : quo_c;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load[OUT_STAGE]) begin
      m_axis_tdata <= {side_q[DIV_STAGES].count,
                       side_q[DIV_STAGES].long_imp,
                       side_q[DIV_STAGES].short_imp,
                       rc_d, rs_d};
    end
  end

  // revised strength never exceeds one
  a_strength_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:0] <= SAT_TOP))
    else $error("revised strength above one");

  // revised confidence never exceeds one
  a_conf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[31:16] <= SAT_TOP))
    else $error("revised confidence above one");

  // count increments or saturates, so it is never zero
  a_count_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[95:64] != '0))
    else $error("access count wrapped");

  // an empty output register never blocks the input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

`default_nettype wire
